// ===== design/ffa_pkg.sv =====
// ----------------------------------------------------------------------------
// ffa_pkg: shared definitions for the first-fit free-list allocator
// Request kinds, status codes, entry layout and rounding constants.
// ----------------------------------------------------------------------------
package ffa_pkg;

  localparam int DefTableDepth = 256;

  // request kinds
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_DROPPED = 2'd2;

  // page rounding
  localparam logic [31:0] PAGE_ADD  = 32'h0000_0fff;
  localparam logic [31:0] PAGE_MASK = 32'hffff_f000;

  // one free region
  typedef struct packed {
    logic [31:0] start;
    logic [31:0] len;
  } region_t;

endpackage

// ===== design/first_fit_free_list_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_free_list_allocator_core
// Free-region table held in one synchronous memory, sorted by address;
// first-fit allocate, coalescing free, running free/lost totals.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                                  | tuser
//  in_*     | in  | block_addr, size_bytes                 | req_type, page_round
//  out_*    | out | result_addr, free_total, entries_used, | status
//           |     | lost_count, lost_bytes                 |
//
// From one accepted request to the next: a query goes straight to its result;
// an allocate or free reads table entries in turn until one matches or the
// used entries run out, then acts on the chosen entry, and, when the table is
// moved, moves the entries behind it one place (an insert also writes the new
// entry). Scan and move cover the table once, through the single memory port.
// Reset (rst_n low, synchronous) empties the table at once; no clearing pass. A
// stalled result holds the block after its next request has been worked through.
// ----------------------------------------------------------------------------
module first_fit_free_list_allocator_core
  import ffa_pkg::*;
#(
  parameter int TABLE_DEPTH = DefTableDepth
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [63:0]  in_tdata,   // block_addr[31:0], size_bytes[63:32]
  input  logic [2:0]   in_tuser,   // req_type[1:0], page_round[2]
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [143:0] out_tdata,  // result_addr[31:0], free_total[63:32],
                                   // entries_used[72:64], lost_count[104:73],
                                   // lost_bytes[136:105], zero pad
  output logic [1:0]   out_tuser   // status[1:0]
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 2);
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_ACT   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]    state_r, state_nxt;
  logic [1:0]    req_r;
  logic [31:0]   addr_r, size_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [31:0]   sum_r, sum_nxt, lcnt_r, lcnt_nxt, lbytes_r, lbytes_nxt;
  logic [CW-1:0] rk_r, rk_nxt, ck_r, ck_nxt, k_r, k_nxt;
  logic          dv_r, dv_nxt, hit_r, hit_nxt;
  region_t       cur_r, cur_nxt, prv_r, prv_nxt;
  logic [CW-1:0] rp_r, rp_nxt, wp_r, wp_nxt, rem_r, rem_nxt;
  logic          wv_r, wv_nxt, up_r, up_nxt;
  logic [1:0]    st_r, st_nxt;
  logic [31:0]   res_r, res_nxt;
  logic          out_valid_r;
  logic [1:0]    out_st_r;
  logic [31:0]   out_res_r, out_sum_r, out_lcnt_r, out_lbytes_r;
  logic [8:0]    out_cnt_r;

  // table memory
  region_t  mem [TABLE_DEPTH];
  region_t  rdata_r;
  logic [AW-1:0] ra;
  logic          we;
  logic [AW-1:0] wa;
  region_t       wd;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rdata_r <= mem[ra];
  end

  logic        in_acc;
  logic [31:0] in_size, in_round;
  logic        scan_match, scan_end;
  logic        merge_p, merge_n, out_load;
  logic [31:0] alloc_len;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_size   = in_tdata[63:32];
  assign in_round  = (in_size + PAGE_ADD) & PAGE_MASK;

  // scan compare on the entry read last cycle
  assign scan_match = (req_r == REQ_ALLOC) ? (rdata_r.len >= size_r)
                                           : (rdata_r.start > addr_r);
  assign scan_end   = (dv_r && scan_match) || (!dv_r && (rk_r >= cnt_r));

  // merge decisions on captured neighbors
  assign merge_p   = (k_r != '0) && ((prv_r.start + prv_r.len) == addr_r);
  assign merge_n   = (k_r < cnt_r) && ((addr_r + size_r) == cur_r.start);
  assign alloc_len = cur_r.len - size_r;
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_tready);

  // sequencer
  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    sum_nxt    = sum_r;
    lcnt_nxt   = lcnt_r;
    lbytes_nxt = lbytes_r;
    rk_nxt     = rk_r;
    ck_nxt     = ck_r;
    dv_nxt     = 1'b0;
    k_nxt      = k_r;
    hit_nxt    = hit_r;
    cur_nxt    = cur_r;
    prv_nxt    = prv_r;
    rp_nxt     = rp_r;
    wp_nxt     = wp_r;
    rem_nxt    = rem_r;
    wv_nxt     = 1'b0;
    up_nxt     = up_r;
    st_nxt     = st_r;
    res_nxt    = res_r;
    ra         = rk_r[AW-1:0];
    we         = 1'b0;
    wa         = k_r[AW-1:0];
    wd         = cur_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          st_nxt  = ST_OK;
          res_nxt = '0;
          rk_nxt  = '0;
          if ((in_tuser[1:0] == REQ_ALLOC) || (in_tuser[1:0] == REQ_FREE)) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      // stream entries through the read port, one per cycle
      S_SCAN: begin
        if (scan_end) begin
          k_nxt     = dv_r ? ck_r : cnt_r;
          hit_nxt   = dv_r;
          cur_nxt   = rdata_r;
          state_nxt = S_ACT;
        end else begin
          if (dv_r) begin
            prv_nxt = rdata_r;
          end
          ra     = rk_r[AW-1:0];
          dv_nxt = (rk_r < cnt_r);
          ck_nxt = rk_r;
          rk_nxt = rk_r + 1'b1;
        end
      end
      // modify the chosen entry, set up any move
      S_ACT: begin
        state_nxt = S_DONE;
        if (req_r == REQ_ALLOC) begin
          if (hit_r) begin
            res_nxt = cur_r.start;
            sum_nxt = sum_r - size_r;
            if (alloc_len == '0) begin
              cnt_nxt   = cnt_r - 1'b1;
              up_nxt    = 1'b0;
              rp_nxt    = k_r + 1'b1;
              rem_nxt   = cnt_r - k_r - 1'b1;
              state_nxt = S_SHIFT;
            end else begin
              we = 1'b1;
              wa = k_r[AW-1:0];
              wd = '{start: cur_r.start + size_r, len: alloc_len};
            end
          end else begin
            st_nxt = ST_NOFIT;
          end
        end else if (merge_p) begin
          sum_nxt = sum_r + size_r;
          we      = 1'b1;
          wa      = AW'(k_r - 1'b1);
          if (merge_n) begin
            wd        = '{start: prv_r.start, len: prv_r.len + size_r + cur_r.len};
            cnt_nxt   = cnt_r - 1'b1;
            up_nxt    = 1'b0;
            rp_nxt    = k_r + 1'b1;
            rem_nxt   = cnt_r - k_r - 1'b1;
            state_nxt = S_SHIFT;
          end else begin
            wd = '{start: prv_r.start, len: prv_r.len + size_r};
          end
        end else if (merge_n) begin
          sum_nxt = sum_r + size_r;
          we      = 1'b1;
          wa      = k_r[AW-1:0];
          wd      = '{start: addr_r, len: cur_r.len + size_r};
        end else if (cnt_r < DEPTH_C) begin
          sum_nxt   = sum_r + size_r;
          cnt_nxt   = cnt_r + 1'b1;
          up_nxt    = 1'b1;
          rp_nxt    = cnt_r - 1'b1;
          rem_nxt   = cnt_r - k_r;
          state_nxt = S_SHIFT;
        end else begin
          st_nxt     = ST_DROPPED;
          lcnt_nxt   = lcnt_r + 1'b1;
          lbytes_nxt = lbytes_r + size_r;
        end
      end
      // move entries one place, read ahead of write
      S_SHIFT: begin
        ra = rp_r[AW-1:0];
        if (rem_r != '0) begin
          wv_nxt  = 1'b1;
          wp_nxt  = up_r ? (rp_r + 1'b1) : (rp_r - 1'b1);
          rp_nxt  = up_r ? (rp_r - 1'b1) : (rp_r + 1'b1);
          rem_nxt = rem_r - 1'b1;
        end
        if (wv_r) begin
          we = 1'b1;
          wa = wp_r[AW-1:0];
          wd = rdata_r;
        end else if (rem_r == '0) begin
          if (up_r) begin
            we = 1'b1;
            wa = k_r[AW-1:0];
            wd = '{start: addr_r, len: size_r};
          end
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_load) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      sum_r       <= '0;
      lcnt_r      <= '0;
      lbytes_r    <= '0;
      dv_r        <= 1'b0;
      wv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      sum_r    <= sum_nxt;
      lcnt_r   <= lcnt_nxt;
      lbytes_r <= lbytes_nxt;
      dv_r     <= dv_nxt;
      wv_r     <= wv_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // request and work registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_r  <= in_tuser[1:0];
      addr_r <= in_tdata[31:0];
      size_r <= in_tuser[2] ? in_round : in_size;
    end
    rk_r  <= rk_nxt;
    ck_r  <= ck_nxt;
    k_r   <= k_nxt;
    hit_r <= hit_nxt;
    cur_r <= cur_nxt;
    prv_r <= prv_nxt;
    rp_r  <= rp_nxt;
    wp_r  <= wp_nxt;
    rem_r <= rem_nxt;
    up_r  <= up_nxt;
    st_r  <= st_nxt;
    res_r <= res_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_st_r     <= st_r;
      out_res_r    <= res_r;
      out_sum_r    <= sum_r;
      out_cnt_r    <= 9'(cnt_r);
      out_lcnt_r   <= lcnt_r;
      out_lbytes_r <= lbytes_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_st_r;
  assign out_tdata  = {7'd0, out_lbytes_r, out_lcnt_r, out_cnt_r, out_sum_r, out_res_r};

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= DEPTH_C) else $error("region count above table depth");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r != S_IDLE)) else $error("request accepted without work");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |=> out_valid_r) else $error("result not presented");

  a_shift_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT && wv_r) |-> (wp_r < cnt_r))
    else $error("table move writes beyond used entries");
`endif

endmodule
